@@ src/kar_pkg.sv @@
// Shared types, constants and layer tables for the key auto-repeat block.
// Used by kar_key_table, key_autorepeat_layer_report and both testbench files; no dependencies.
package kar_pkg;

    localparam int ROWS = 4;
    localparam int COLS = 6;
    localparam int NKEYS = ROWS * COLS;

    localparam int ROW_W = 2;
    localparam int COL_W = 3;
    localparam int KEY_IDX_W = 5;
    localparam int TIME_W = 32;
    localparam int INTERVAL_W = 10;
    localparam int MOD_W = 5;
    localparam int CODE_W = 8;

    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_INDEX_W = 3;

    localparam logic [INTERVAL_W-1:0] FIRST_DELAY_MS = INTERVAL_W'(560);
    localparam logic [INTERVAL_W-1:0] REPEAT_MS = INTERVAL_W'(40);
    localparam logic [INTERVAL_W-1:0] RELEASE_MS = INTERVAL_W'(16);

    localparam logic [KEY_IDX_W-1:0] KEY_NONE = KEY_IDX_W'(24);

    localparam logic [CFG_INDEX_W-1:0] CFG_SHIFT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTROL = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAYER = 3'd4;

    typedef enum logic [2:0] {
        ROLE_NONE,
        ROLE_SHIFT,
        ROLE_WIN,
        ROLE_CONTROL,
        ROLE_ALT,
        ROLE_LAYER
    } role_t;

    typedef struct packed {
        logic                  fire;
        logic [KEY_IDX_W-1:0]  idx;
        logic                  released;
        logic [TIME_W-1:0]     now_ms;
    } key_req_t;

    localparam logic [CODE_W-1:0] BASE_ROM [NKEYS] = '{
        8'd23, 8'd21, 8'd8,  8'd26, 8'd20, 8'd41,
        8'd10, 8'd9,  8'd7,  8'd22, 8'd4,  8'd43,
        8'd5,  8'd25, 8'd6,  8'd27, 8'd29, 8'd225,
        8'd42, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0
    };

    localparam logic [CODE_W-1:0] ALT_ROM [NKEYS] = '{
        8'd0,  8'd0,  8'd0,  8'd0, 8'd0, 8'd0,
        8'd49, 8'd48, 8'd47, 8'd0, 8'd0, 8'd0,
        8'd0,  8'd0,  8'd0,  8'd0, 8'd0, 8'd0,
        8'd0,  8'd0,  8'd0,  8'd0, 8'd0, 8'd0
    };

endpackage

@@ src/kar_key_table.sv @@
// Per-key held flag, wait interval and last accepted time, one read and update per cycle.
// Depends on kar_pkg for widths, timing constants and the request struct.
module kar_key_table (
    input  logic              clk,
    input  logic              rst_n,
    input  kar_pkg::key_req_t req,
    output logic              due
);

    logic                            held_reg [kar_pkg::NKEYS];
    logic [kar_pkg::INTERVAL_W-1:0]  wait_reg [kar_pkg::NKEYS];
    logic [kar_pkg::TIME_W-1:0]      last_reg [kar_pkg::NKEYS];

    logic [kar_pkg::TIME_W-1:0] elapsed;

    assign elapsed = req.now_ms - last_reg[req.idx];
    assign due = elapsed >= kar_pkg::TIME_W'(wait_reg[req.idx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kar_pkg::NKEYS; i++)
            begin
                held_reg[i] <= 1'b0;
                wait_reg[i] <= kar_pkg::FIRST_DELAY_MS;
                last_reg[i] <= '0;
            end
        end
        else if (req.fire)
        begin
            if (req.released)
            begin
                held_reg[req.idx] <= 1'b0;
                wait_reg[req.idx] <= kar_pkg::RELEASE_MS;
            end
            else if (due)
            begin
                held_reg[req.idx] <= 1'b1;
                last_reg[req.idx] <= req.now_ms;
                wait_reg[req.idx] <= held_reg[req.idx] ? kar_pkg::REPEAT_MS
                                                       : kar_pkg::FIRST_DELAY_MS;
            end
        end
    end

endmodule

@@ src/key_autorepeat_layer_report.sv @@
// Top level of the key auto-repeat block: input and result registers, modifier
// and layer flags, role decode and layer lookup. Depends on kar_pkg, kar_key_table.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one key sample per item. s_tdata holds,
//   from the lowest bit up: key_row[1:0], key_col[4:2], is_released[5],
//   now_ms[37:6], zero fill to 40 bits.
//   m_tvalid/m_tready/m_tdata carry one report per sample. m_tdata holds,
//   from the lowest bit up: modifier_bits[4:0], key_code[12:5], zero fill.
//   cfg_we/cfg_index/cfg_data write the role registers (shift, win, control,
//   alt, layer key index); write only while no item is in flight.
// Path: a sample is held in the input register, then its report in the result register.
// Throughput: one item per cycle while m_tready is high; the per-key table
// update in the processing stage is the loop that sets this.
// Reset: all keys released with a 560 ms first delay, all flags clear, base
// layer, role registers set to no key. No clearing pass is needed.
// Stall: while m_tready is low the report holds, one more sample waits in the
// input register, and s_tready then drops until the report is taken.
module key_autorepeat_layer_report (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [kar_pkg::IN_DATA_W-1:0]       s_tdata,   // key_row, key_col, is_released, now_ms
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [kar_pkg::OUT_DATA_W-1:0]      m_tdata,   // modifier_bits, key_code
    input  logic                                cfg_we,
    input  logic [kar_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [kar_pkg::KEY_IDX_W-1:0]       cfg_data
);

    logic [kar_pkg::KEY_IDX_W-1:0] shift_idx_reg;
    logic [kar_pkg::KEY_IDX_W-1:0] win_idx_reg;
    logic [kar_pkg::KEY_IDX_W-1:0] control_idx_reg;
    logic [kar_pkg::KEY_IDX_W-1:0] alt_idx_reg;
    logic [kar_pkg::KEY_IDX_W-1:0] layer_idx_reg;

    logic                          in_valid_reg;
    logic [kar_pkg::ROW_W-1:0]     row_reg;
    logic [kar_pkg::COL_W-1:0]     col_reg;
    logic                          released_reg;
    logic [kar_pkg::TIME_W-1:0]    now_reg;

    logic                          out_valid_reg;
    logic [kar_pkg::MOD_W-1:0]     mods_reg;
    logic [kar_pkg::CODE_W-1:0]    code_reg;

    logic shift_on_reg, win_on_reg, control_on_reg, alt_on_reg, layer_on_reg;
    logic shift_on_next, win_on_next, control_on_next, alt_on_next, layer_on_next;

    logic                          advance;
    logic                          in_range;
    logic [kar_pkg::KEY_IDX_W-1:0] key_idx;
    kar_pkg::role_t                role;
    kar_pkg::key_req_t             req;
    logic                          due;
    logic [kar_pkg::MOD_W-1:0]     mods_next;
    logic [kar_pkg::CODE_W-1:0]    code_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = {3'b000, code_reg, mods_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_idx_reg <= kar_pkg::KEY_NONE;
            win_idx_reg <= kar_pkg::KEY_NONE;
            control_idx_reg <= kar_pkg::KEY_NONE;
            alt_idx_reg <= kar_pkg::KEY_NONE;
            layer_idx_reg <= kar_pkg::KEY_NONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kar_pkg::CFG_SHIFT:   shift_idx_reg <= cfg_data;
                kar_pkg::CFG_WIN:     win_idx_reg <= cfg_data;
                kar_pkg::CFG_CONTROL: control_idx_reg <= cfg_data;
                kar_pkg::CFG_ALT:     alt_idx_reg <= cfg_data;
                kar_pkg::CFG_LAYER:   layer_idx_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            row_reg <= s_tdata[1:0];
            col_reg <= s_tdata[4:2];
            released_reg <= s_tdata[5];
            now_reg <= s_tdata[37:6];
        end
    end

    assign in_range = (int'(row_reg) < kar_pkg::ROWS) && (int'(col_reg) < kar_pkg::COLS);
    assign key_idx = kar_pkg::KEY_IDX_W'(int'(row_reg) * kar_pkg::COLS + int'(col_reg));

    always_comb
    begin
        if (key_idx == shift_idx_reg)
            role = kar_pkg::ROLE_SHIFT;
        else if (key_idx == win_idx_reg)
            role = kar_pkg::ROLE_WIN;
        else if (key_idx == control_idx_reg)
            role = kar_pkg::ROLE_CONTROL;
        else if (key_idx == alt_idx_reg)
            role = kar_pkg::ROLE_ALT;
        else if (key_idx == layer_idx_reg)
            role = kar_pkg::ROLE_LAYER;
        else
            role = kar_pkg::ROLE_NONE;
    end

    always_comb
    begin
        req.fire = advance && in_range;
        req.idx = key_idx;
        req.released = released_reg;
        req.now_ms = now_reg;
    end

    kar_key_table u_key_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .due   (due)
    );

    always_comb
    begin
        logic set_flag;
        logic flag_value;
        set_flag = 1'b0;
        flag_value = 1'b0;
        code_next = '0;
        shift_on_next = shift_on_reg;
        win_on_next = win_on_reg;
        control_on_next = control_on_reg;
        alt_on_next = alt_on_reg;
        layer_on_next = layer_on_reg;
        if (in_range)
        begin
            if (released_reg)
            begin
                set_flag = 1'b1;
                flag_value = 1'b0;
            end
            else if (due)
            begin
                if (role == kar_pkg::ROLE_NONE)
                    code_next = layer_on_reg ? kar_pkg::ALT_ROM[key_idx]
                                             : kar_pkg::BASE_ROM[key_idx];
                else
                begin
                    set_flag = 1'b1;
                    flag_value = 1'b1;
                end
            end
        end
        if (set_flag)
        begin
            case (role)
                kar_pkg::ROLE_SHIFT:   shift_on_next = flag_value;
                kar_pkg::ROLE_WIN:     win_on_next = flag_value;
                kar_pkg::ROLE_CONTROL: control_on_next = flag_value;
                kar_pkg::ROLE_ALT:     alt_on_next = flag_value;
                kar_pkg::ROLE_LAYER:   layer_on_next = flag_value;
                default: ;
            endcase
        end
        mods_next = {control_on_next, win_on_next, alt_on_next, shift_on_next, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_on_reg <= 1'b0;
            win_on_reg <= 1'b0;
            control_on_reg <= 1'b0;
            alt_on_reg <= 1'b0;
            layer_on_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                shift_on_reg <= shift_on_next;
                win_on_reg <= win_on_next;
                control_on_reg <= control_on_next;
                alt_on_reg <= alt_on_next;
                layer_on_reg <= layer_on_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mods_reg <= mods_next;
            code_reg <= code_next;
        end
    end

endmodule

@@ tb/kar_report_checker.sv @@
// Report checker for key_autorepeat_layer_report: mirrors role registers and per-key
// typematic state, predicts one report per accepted key sample, compares on the output.
// Depends on kar_pkg for port widths, register indexes and the role enum.
module kar_report_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [kar_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [kar_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_we,
    input  logic [kar_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [kar_pkg::KEY_IDX_W-1:0]   cfg_data,
    output int                              mismatches,
    output int                              reports_due
);

    localparam int         KEY_COUNT    = 24;
    localparam logic [9:0] FIRST_WAIT   = 10'd560;
    localparam logic [9:0] REPEAT_WAIT  = 10'd40;
    localparam logic [9:0] RELEASE_WAIT = 10'd16;
    localparam logic [4:0] NO_KEY       = 5'd24;

    localparam logic [7:0] BASE_CODES [KEY_COUNT] = '{
        8'd23, 8'd21, 8'd8,  8'd26, 8'd20, 8'd41,
        8'd10, 8'd9,  8'd7,  8'd22, 8'd4,  8'd43,
        8'd5,  8'd25, 8'd6,  8'd27, 8'd29, 8'd225,
        8'd42, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0
    };

    localparam logic [7:0] LAYER_CODES [KEY_COUNT] = '{
        8'd0,  8'd0,  8'd0,  8'd0, 8'd0, 8'd0,
        8'd49, 8'd48, 8'd47, 8'd0, 8'd0, 8'd0,
        8'd0,  8'd0,  8'd0,  8'd0, 8'd0, 8'd0,
        8'd0,  8'd0,  8'd0,  8'd0, 8'd0, 8'd0
    };

    typedef struct packed {
        logic [kar_pkg::MOD_W-1:0]  mods;
        logic [kar_pkg::CODE_W-1:0] code;
    } report_t;

    logic [kar_pkg::KEY_IDX_W-1:0] shift_key, win_key, control_key, alt_key, layer_key;
    logic                 held    [KEY_COUNT];
    logic [9:0]           wait_ms [KEY_COUNT];
    logic [31:0]          last_ms [KEY_COUNT];
    logic                 shift_on, win_on, control_on, alt_on, layer_on;
    report_t              report_q [$];
    report_t              got, want;
    int                   new_fails;

    function automatic kar_pkg::role_t role_of(input logic [kar_pkg::KEY_IDX_W-1:0] key);
        if (key == shift_key) return kar_pkg::ROLE_SHIFT;
        if (key == win_key) return kar_pkg::ROLE_WIN;
        if (key == control_key) return kar_pkg::ROLE_CONTROL;
        if (key == alt_key) return kar_pkg::ROLE_ALT;
        if (key == layer_key) return kar_pkg::ROLE_LAYER;
        return kar_pkg::ROLE_NONE;
    endfunction

    function automatic void set_role(input kar_pkg::role_t role, input logic level);
        case (role)
            kar_pkg::ROLE_SHIFT:   shift_on = level;
            kar_pkg::ROLE_WIN:     win_on = level;
            kar_pkg::ROLE_CONTROL: control_on = level;
            kar_pkg::ROLE_ALT:     alt_on = level;
            kar_pkg::ROLE_LAYER:   layer_on = level;
            default:               ;
        endcase
    endfunction

    function automatic report_t predict_report(input logic [kar_pkg::IN_DATA_W-1:0] item);
        logic [1:0]     row;
        logic [2:0]     col;
        logic           released;
        logic [31:0]    stamp;
        logic [31:0]    elapsed;
        int             idx;
        kar_pkg::role_t role;
        report_t        rep;
        row = item[1:0];
        col = item[4:2];
        released = item[5];
        stamp = item[37:6];
        rep.code = '0;
        if (col < 3'(kar_pkg::COLS))
        begin
            idx = int'(row) * kar_pkg::COLS + int'(col);
            role = role_of(5'(idx));
            if (!released)
            begin
                elapsed = stamp - last_ms[idx];
                if (elapsed >= 32'(wait_ms[idx]))
                begin
                    last_ms[idx] = stamp;
                    wait_ms[idx] = held[idx] ? REPEAT_WAIT : FIRST_WAIT;
                    held[idx] = 1'b1;
                    if (role != kar_pkg::ROLE_NONE)
                        set_role(role, 1'b1);
                    else
                        rep.code = layer_on ? LAYER_CODES[idx] : BASE_CODES[idx];
                end
            end
            else
            begin
                wait_ms[idx] = RELEASE_WAIT;
                held[idx] = 1'b0;
                if (role != kar_pkg::ROLE_NONE)
                    set_role(role, 1'b0);
            end
        end
        rep.mods = {control_on, win_on, alt_on, shift_on, 1'b0};
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_key = NO_KEY;
            win_key = NO_KEY;
            control_key = NO_KEY;
            alt_key = NO_KEY;
            layer_key = NO_KEY;
            for (int i = 0; i < KEY_COUNT; i++)
            begin
                held[i] = 1'b0;
                wait_ms[i] = FIRST_WAIT;
                last_ms[i] = '0;
            end
            shift_on = 1'b0;
            win_on = 1'b0;
            control_on = 1'b0;
            alt_on = 1'b0;
            layer_on = 1'b0;
            report_q.delete();
            mismatches <= 0;
            reports_due <= 0;
        end
        else
        begin
            new_fails = 0;
            if (m_tvalid && m_tready)
            begin
                got.mods = m_tdata[kar_pkg::MOD_W-1:0];
                got.code = m_tdata[kar_pkg::MOD_W +: kar_pkg::CODE_W];
                if (report_q.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, got mods %0h code %0d",
                             $time, got.mods, got.code);
                    new_fails = 1;
                end
                else
                begin
                    want = report_q.pop_front();
                    if (got.mods !== want.mods)
                    begin
                        $display("%0t: modifier_bits expected %0h, got %0h",
                                 $time, want.mods, got.mods);
                        new_fails++;
                    end
                    if (got.code !== want.code)
                    begin
                        $display("%0t: key_code expected %0d, got %0d",
                                 $time, want.code, got.code);
                        new_fails++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    kar_pkg::CFG_SHIFT:   shift_key = cfg_data;
                    kar_pkg::CFG_WIN:     win_key = cfg_data;
                    kar_pkg::CFG_CONTROL: control_key = cfg_data;
                    kar_pkg::CFG_ALT:     alt_key = cfg_data;
                    kar_pkg::CFG_LAYER:   layer_key = cfg_data;
                    default:              ;
                endcase
            end
            if (s_tvalid && s_tready)
                report_q.push_back(predict_report(s_tdata));
            mismatches <= mismatches + new_fails;
            reports_due <= report_q.size();
        end
    end

endmodule

@@ tb/tb_key_autorepeat_layer_report.sv @@
// Testbench top for key_autorepeat_layer_report: clock, reset, role register writes,
// directed and random key samples with idle bursts, verdict. Depends on kar_pkg,
// kar_report_checker and the block itself.
module tb_key_autorepeat_layer_report;

    localparam int QUIET_LIMIT   = 500;
    localparam int BLOCK_SAMPLES = 150;
    localparam logic [kar_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = kar_pkg::CFG_LAYER + 3'd1;
    localparam logic [kar_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = '1;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [kar_pkg::IN_DATA_W-1:0]   s_tdata = '0;     // key_row, key_col, is_released, now_ms
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [kar_pkg::OUT_DATA_W-1:0]  m_tdata;          // modifier_bits, key_code
    logic                            cfg_we = 1'b0;
    logic [kar_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [kar_pkg::KEY_IDX_W-1:0]   cfg_data = '0;
    int                              mismatches;
    int                              reports_due;
    int                              quiet_cycles = 0;
    int                              stall_left = 0;
    int                              samples_sent = 0;
    logic                            idling = 1'b0;
    logic [31:0]                     clock_ms = '0;

    key_autorepeat_layer_report uut (.*);

    kar_report_checker checker_i (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 11);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("key_autorepeat_layer_report test failed");
            $finish;
        end
    end

    task automatic send_sample(input logic [1:0] row, input logic [2:0] col,
                               input logic released, input logic [31:0] stamp);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, stamp, released, col, row};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (col < 3'(kar_pkg::COLS))
            samples_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0) @(posedge clk);
    endtask

    task automatic put_reg(input logic [kar_pkg::CFG_INDEX_W-1:0] index,
                           input logic [kar_pkg::KEY_IDX_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic load_roles(input logic [kar_pkg::KEY_IDX_W-1:0] shift_key, win_key,
                              control_key, alt_key, layer_key);
        put_reg(kar_pkg::CFG_SHIFT, shift_key);
        put_reg(kar_pkg::CFG_WIN, win_key);
        put_reg(kar_pkg::CFG_CONTROL, control_key);
        put_reg(kar_pkg::CFG_ALT, alt_key);
        put_reg(kar_pkg::CFG_LAYER, layer_key);
        put_reg(CFG_SPARE_LO, 5'($urandom));
        put_reg(CFG_SPARE_HI, 5'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] next_gap();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 20);
            1:       return $urandom_range(12, 20);
            2:       return $urandom_range(36, 44);
            3:       return $urandom_range(550, 570);
            4:       return $urandom_range(40, 200);
            default: return $urandom_range(0, 1100);
        endcase
    endfunction

    task automatic run_random(input int count, input logic allow_idle);
        logic [1:0] row;
        logic [2:0] col;
        int         stop_at;
        stop_at = samples_sent + count;
        while (samples_sent < stop_at)
        begin
            idling = allow_idle && ($urandom_range(0, 3) != 0);
            row = 2'($urandom_range(0, 3));
            col = 3'($urandom_range(0, kar_pkg::COLS - 1));
            case ($urandom_range(0, 9))
                7:
                    repeat ($urandom_range(1, 4))
                        send_sample(2'($urandom), 3'($urandom), 1'($urandom), $urandom);
                8:
                    clock_ms += $urandom;
                9:
                    send_sample(row, 3'($urandom_range(kar_pkg::COLS, 7)), 1'($urandom),
                                clock_ms);
                default:
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        clock_ms += next_gap();
                        send_sample(row, col, 1'b0, clock_ms);
                    end
                    if ($urandom_range(0, 3) != 0)
                    begin
                        clock_ms += next_gap();
                        send_sample(row, col, 1'b1, clock_ms);
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_roles(5'd0, 5'd5, 5'd23, 5'd12, 5'd18);
        idling = 1'b1;

        send_sample(2'd1, 3'd0, 1'b0, 32'd559);
        send_sample(2'd1, 3'd0, 1'b0, 32'd560);
        send_sample(2'd1, 3'd0, 1'b0, 32'd599);
        send_sample(2'd1, 3'd0, 1'b0, 32'd600);
        send_sample(2'd1, 3'd0, 1'b1, 32'd605);
        send_sample(2'd1, 3'd0, 1'b0, 32'd615);
        send_sample(2'd1, 3'd0, 1'b0, 32'd616);
        send_sample(2'd0, 3'd0, 1'b0, 32'd700);
        send_sample(2'd0, 3'd5, 1'b0, 32'd700);
        send_sample(2'd3, 3'd5, 1'b0, 32'd700);
        send_sample(2'd2, 3'd0, 1'b0, 32'd700);
        send_sample(2'd3, 3'd0, 1'b0, 32'd700);
        send_sample(2'd1, 3'd1, 1'b0, 32'd800);
        send_sample(2'd0, 3'd1, 1'b0, 32'd800);
        send_sample(2'd3, 3'd0, 1'b1, 32'd810);
        send_sample(2'd2, 3'd5, 1'b0, 32'd900);
        send_sample(2'd0, 3'd0, 1'b1, 32'd900);
        send_sample(2'd0, 3'd3, 1'b1, 32'd900);
        send_sample(2'd2, 3'd6, 1'b0, 32'd900);
        send_sample(2'd3, 3'd7, 1'b1, 32'd900);
        send_sample(2'd0, 3'd2, 1'b0, 32'hFFFF_FFF0);
        send_sample(2'd0, 3'd2, 1'b0, 32'h0000_0010);
        send_sample(2'd0, 3'd2, 1'b0, 32'h0000_0220);
        send_sample(2'd3, 3'd1, 1'b0, 32'd1000);

        settle();
        load_roles(5'd7, 5'd7, 5'd0, 5'd31, kar_pkg::KEY_NONE);
        run_random(BLOCK_SAMPLES, 1'b1);

        settle();
        load_roles(5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
        run_random(BLOCK_SAMPLES, 1'b1);

        settle();
        load_roles(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                   5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), 5'd7);
        run_random(BLOCK_SAMPLES, 1'b1);

        settle();
        load_roles(5'($urandom_range(0, 23)), 5'($urandom_range(0, 23)),
                   5'($urandom_range(0, 23)), 5'($urandom_range(0, 23)), 5'd8);
        run_random(BLOCK_SAMPLES - 30, 1'b0);

        idling = 1'b0;
        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && reports_due == 0)
            $display("key_autorepeat_layer_report test passed");
        else
            $display("key_autorepeat_layer_report test failed");
        $finish;
    end

endmodule
